// ----- sv/crd_pkg.sv -----
// Package for the capture record deframer: widths, codes and constants.
// Used by every module of the block.
package crd_pkg;
    localparam int OFFSET_W = 35;
    localparam int HZ_W = 32;
    localparam int LEN_W = 16;
    localparam int REM_W = 17;
    localparam int SEC_W = 35;
    localparam int NSF_W = 30;
    localparam int DEF_MAX_PACKET_BYTES = 16384;
    localparam int CYCLE_BYTES = 64;
    localparam logic [55:0] SIG_VALUE = 56'h666C6F57202E44;
    localparam logic [63:0] NS_PER_S = 64'd1000000000;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

    localparam logic [0:0] REG_BANK = 1'b0;
    localparam logic [0:0] REG_HZ = 1'b1;

    typedef enum logic [1:0] {
        K_HEADER = 2'd0,
        K_DATA = 2'd1,
        K_END = 2'd2,
        K_ERROR = 2'd3
    } kind_t;

    // controller to datapath
    typedef struct packed {
        logic start_div;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic busy;
        logic done;
    } dp_stat_t;
endpackage

// ----- sv/capture_record_deframer.sv -----
// Top level of the capture record deframer: controller plus conversion unit.
// Depends on crd_pkg, crd_ctrl, crd_divider.
//
//  channel  | handshake             | payload
//  input    | in_valid / in_stall   | ram_word
//  output   | out_valid / out_stall | kind, stamp_*, packet_length, data_word, last
//  config   | cfg_we                | cfg_index, cfg_data
//
// One word per cycle when not stalled; after header word 2 the input stalls for setup,
// the multiply, the seconds and nanoseconds divider passes, and the result load.
// Reset clears offset, phase and bank register, sets the rate to 1; no clearing pass.
// Output stall holds the input once a result is waiting.
module capture_record_deframer
    import crd_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [OFFSET_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [63:0]        ram_word,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic [SEC_W-1:0]   stamp_sec,
    output logic [NSF_W-1:0]   stamp_nsec,
    output logic [LEN_W-1:0]   packet_length,
    output logic [63:0]        data_word,
    output logic               last
);
    dp_cmd_t cmd;
    dp_stat_t stat;
    logic [63:0] clocks;
    logic [HZ_W-1:0] hz;
    logic hdr_sel;
    logic [SEC_W-1:0] sec;
    logic [NSF_W-1:0] nsf;

    crd_ctrl #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx_ok(~cfg_index[1]),
        .cfg_sel(cfg_index[0]), .cfg_data(cfg_data), .in_valid(in_valid),
        .in_stall(in_stall), .in_word(ram_word), .out_valid(out_valid),
        .out_stall(out_stall), .kind(kind), .packet_length(packet_length),
        .data_word(data_word), .last(last), .hdr_sel(hdr_sel), .cmd(cmd),
        .stat(stat), .clocks(clocks), .hz(hz)
    );

    crd_divider u_div (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .clocks(clocks), .hz(hz),
        .stat(stat), .seconds(sec), .nanos(nsf)
    );

    assign stamp_sec = hdr_sel ? sec : '0;
    assign stamp_nsec = hdr_sel ? nsf : '0;
endmodule

// ----- sv/crd_divider.sv -----
// Datapath: timestamp conversion. Multiplies clocks by 10^9 in 32x32 partial products,
// divides by rate*10^9 for seconds, then the remainder by rate for nanoseconds, one
// quotient bit a cycle. Depends on crd_pkg.
module crd_divider
    import crd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    input  logic [63:0]       clocks,
    input  logic [HZ_W-1:0]   hz,
    output dp_stat_t          stat,
    output logic [SEC_W-1:0]  seconds,
    output logic [NSF_W-1:0]  nanos
);
    typedef enum logic [2:0] {S_IDLE, S_MUL0, S_MUL1, S_DIV1, S_DIV2} st_t;
    st_t st_reg;
    logic [6:0] cnt_reg;
    logic [63:0] prod_reg;
    logic [63:0] quo_reg;
    logic [63:0] rem_reg;
    logic [63:0] den_reg;
    logic [63:0] pp_reg;
    logic [SEC_W-1:0] sec_reg;
    logic done_reg;

    logic [64:0] trial;
    logic [63:0] shifted;
    logic [63:0] quo_next;
    logic [63:0] rem_next;
    logic [HZ_W-1:0] hz_eff;
    always_comb
    begin
        shifted = {rem_reg[62:0], quo_reg[63]};
        trial = {rem_reg, quo_reg[63]} - {1'b0, den_reg};
        quo_next = {quo_reg[62:0], ~trial[64]};
        rem_next = trial[64] ? shifted : trial[63:0];
        hz_eff = (hz == '0) ? HZ_W'(1) : hz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            done_reg <= 1'b0;
            cnt_reg <= '0;
            prod_reg <= '0;
            quo_reg <= '0;
            rem_reg <= '0;
            den_reg <= '0;
            pp_reg <= '0;
            sec_reg <= '0;
        end
        else
        begin
            done_reg <= (st_reg == S_DIV2) && (cnt_reg == 7'd63);
            unique case (st_reg)
                S_IDLE:
                    if (cmd.start_div)
                    begin
                        // low half of clocks times 10^9
                        pp_reg <= {32'd0, clocks[31:0]} * {32'd0, NS_PER_S[31:0]};
                        st_reg <= S_MUL0;
                    end
                S_MUL0:
                begin
                    prod_reg <= pp_reg;
                    pp_reg <= {32'd0, clocks[63:32]} * {32'd0, NS_PER_S[31:0]};
                    st_reg <= S_MUL1;
                end
                S_MUL1:
                begin
                    quo_reg <= prod_reg + {pp_reg[31:0], 32'd0};
                    rem_reg <= '0;
                    den_reg <= {32'd0, hz_eff} * {34'd0, NS_PER_S[29:0]};
                    cnt_reg <= 7'd0;
                    st_reg <= S_DIV1;
                end
                S_DIV1, S_DIV2:
                begin
                    if (cnt_reg != 7'd63)
                    begin
                        quo_reg <= quo_next;
                        rem_reg <= rem_next;
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                    else if (st_reg == S_DIV1)
                    begin
                        // seconds done; divide the remainder by the rate for nanoseconds
                        sec_reg <= quo_next[SEC_W-1:0];
                        quo_reg <= rem_next;
                        rem_reg <= '0;
                        den_reg <= {32'd0, hz_eff};
                        cnt_reg <= 7'd0;
                        st_reg <= S_DIV2;
                    end
                    else
                    begin
                        quo_reg <= quo_next;
                        rem_reg <= rem_next;
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign stat.busy = (st_reg != S_IDLE);
    assign stat.done = done_reg;
    assign seconds = sec_reg;
    assign nanos = quo_reg[NSF_W-1:0];
endmodule

// ----- sv/crd_ctrl.sv -----
// Controller: walks header and data cycles, checks bounds, drives the
// output register and starts timestamp conversion. Depends on crd_pkg.
module crd_ctrl
    import crd_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_idx_ok,
    input  logic                cfg_sel,
    input  logic [HZ_W+2:0]     cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [63:0]         in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          kind,
    output logic [LEN_W-1:0]    packet_length,
    output logic [63:0]         data_word,
    output logic                last,
    output logic                hdr_sel,
    output dp_cmd_t             cmd,
    input  dp_stat_t            stat,
    output logic [63:0]         clocks,
    output logic [HZ_W-1:0]     hz
);
    typedef enum logic [1:0] {P_HEADER, P_DATA, P_WAIT, P_STOP} ph_t;
    ph_t ph_reg;
    logic [OFFSET_W-1:0] off_reg, bank_reg;
    logic [2:0] wic_reg;
    logic [LEN_W-1:0] len_reg;
    logic [REM_W-1:0] rem_reg;
    logic [HZ_W-1:0] hz_reg;
    logic [63:0] ts_reg;

    logic take;
    logic [OFFSET_W+1:0] need;
    logic [OFFSET_W-1:0] off_inc;
    logic [OFFSET_W:0] off_sum;
    logic [LEN_W-1:0] wlen;

    assign in_stall = (ph_reg == P_WAIT) || stat.busy || (out_valid && out_stall);
    assign take = in_valid && !in_stall;
    assign wlen = in_word[LEN_W-1:0];
    assign need = {2'b0, off_reg} + (OFFSET_W+2)'(CYCLE_BYTES)
                  + {{(OFFSET_W+2-LEN_W){1'b0}}, wlen};
    assign off_sum = {1'b0, off_reg} + (OFFSET_W+1)'(CYCLE_BYTES);
    assign off_inc = off_sum[OFFSET_W] ? OFFSET_MAX : off_sum[OFFSET_W-1:0];
    assign clocks = ts_reg;
    assign hz = hz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= P_HEADER;
            off_reg <= '0;
            bank_reg <= '0;
            hz_reg <= HZ_W'(1);
            wic_reg <= '0;
            len_reg <= '0;
            rem_reg <= '0;
            ts_reg <= '0;
            out_valid <= 1'b0;
            cmd <= '0;
            kind <= K_HEADER;
            packet_length <= '0;
            data_word <= '0;
            last <= 1'b0;
            hdr_sel <= 1'b0;
        end
        else
        begin
            cmd.start_div <= 1'b0;
            if (cfg_we && cfg_idx_ok[0])
            begin
                if (cfg_sel == REG_BANK)
                    bank_reg <= cfg_data[OFFSET_W-1:0];
                else
                    hz_reg <= cfg_data[HZ_W-1:0];
            end
            if (out_valid && !out_stall)
                out_valid <= 1'b0;
            if (ph_reg == P_WAIT && stat.done)
            begin
                out_valid <= 1'b1;
                ph_reg <= (wic_reg == '0 && rem_reg != '0) ? P_DATA : P_HEADER;
            end
            if (take)
            begin
                unique case (ph_reg)
                    P_HEADER:
                    begin
                        wic_reg <= wic_reg + 3'd1;
                        if (wic_reg == 3'd0 && (off_reg >= bank_reg
                            || in_word[55:0] != SIG_VALUE))
                        begin
                            ph_reg <= P_STOP;
                            {kind, packet_length, data_word, last, hdr_sel}
                                <= {K_END, {LEN_W{1'b0}}, 64'd0, 1'b1, 1'b0};
                            out_valid <= 1'b1;
                        end
                        else if (wic_reg == 3'd1)
                            ts_reg <= in_word;
                        else if (wic_reg == 3'd2)
                        begin
                            if (32'(wlen) > MAX_PACKET_BYTES)
                            begin
                                ph_reg <= P_STOP;
                                {kind, packet_length, data_word, last, hdr_sel}
                                    <= {K_ERROR, wlen, 64'd0, 1'b1, 1'b0};
                                out_valid <= 1'b1;
                            end
                            else if (need > {2'b0, bank_reg})
                            begin
                                ph_reg <= P_STOP;
                                {kind, packet_length, data_word, last, hdr_sel}
                                    <= {K_END, {LEN_W{1'b0}}, 64'd0, 1'b1, 1'b0};
                                out_valid <= 1'b1;
                            end
                            else
                            begin
                                len_reg <= wlen;
                                rem_reg <= {1'b0, wlen};
                                {kind, packet_length, data_word, last, hdr_sel}
                                    <= {K_HEADER, wlen, 64'd0, wlen == '0, 1'b1};
                                cmd.start_div <= 1'b1;
                                ph_reg <= P_WAIT;
                            end
                        end
                        if (wic_reg == 3'd7)
                        begin
                            off_reg <= off_inc;
                            ph_reg <= (rem_reg != '0) ? P_DATA : P_HEADER;
                        end
                    end
                    P_DATA:
                    begin
                        if (rem_reg != '0)
                        begin
                            {kind, packet_length, data_word, last, hdr_sel}
                                <= {K_DATA, len_reg, in_word, rem_reg <= REM_W'(8), 1'b0};
                            rem_reg <= (rem_reg <= REM_W'(8)) ? '0 : rem_reg - REM_W'(8);
                            out_valid <= 1'b1;
                        end
                        wic_reg <= wic_reg + 3'd1;
                        if (wic_reg == 3'd7)
                        begin
                            off_reg <= off_inc;
                            if (rem_reg <= REM_W'(8))
                                ph_reg <= P_HEADER;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule

// ----- sv/crd_checker.sv -----
// Port checker for the capture record deframer, bound to the top level.
// Depends on crd_pkg.
module crd_checker
    import crd_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input logic [1:0] kind,
    input logic [63:0] data_word,
    input logic last
);
    ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind))
        else $error("output dropped under stall");
    ap_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == K_END || kind == K_ERROR) |-> last)
        else $error("end without last");
    ap_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && (kind == K_END || kind == K_ERROR) |=> !out_valid)
        else $error("result after stop");
    ap_data0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != K_DATA |-> data_word == 64'd0)
        else $error("data word on non-data result");
endmodule

bind capture_record_deframer crd_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .data_word(data_word), .last(last)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench for capture_record_deframer: directed table, then random records.
// Depends on crd_pkg and the deframer RTL; predicts every result beat in the bench.
module tb_top
    import crd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int MAX_LEN = 16384;
    localparam logic [1:0] IDX_BANK = 2'd0;
    localparam logic [1:0] IDX_HZ = 2'd1;
    localparam logic [1:0] IDX_BAD = 2'd3;
    localparam logic [1:0] PH_HDR = 2'd0;
    localparam logic [1:0] PH_DAT = 2'd1;
    localparam logic [1:0] PH_STOP = 2'd2;

    typedef struct {
        kind_t             kind;
        logic [SEC_W-1:0]  sec;
        logic [NSF_W-1:0]  nsec;
        logic [LEN_W-1:0]  len;
        logic [63:0]       data;
        logic              last;
    } rec_beat_t;

    typedef struct {
        logic [63:0] word;
        bit          typed;
        rec_beat_t   exp;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [OFFSET_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [63:0] ram_word = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] kind;
    logic [SEC_W-1:0] stamp_sec;
    logic [NSF_W-1:0] stamp_nsec;
    logic [LEN_W-1:0] packet_length;
    logic [63:0] data_word;
    logic last;

    capture_record_deframer dut (.*);

    always #10 clk = ~clk;

    // predictor state
    logic [OFFSET_W-1:0] bank_bytes;
    logic [HZ_W-1:0]     clock_hz;
    logic [OFFSET_W-1:0] cur_offset;
    logic [1:0]          phase;
    int unsigned         word_idx;
    logic [63:0]         ts_clocks;
    logic [LEN_W-1:0]    rec_len;
    int unsigned         bytes_left;

    rec_beat_t   pending_beats[$];
    row_t        dir_rows[$];
    int          errors = 0;
    int          idle_pct = 22;
    longint      cycles = 0;

    function automatic void write_reg(input logic [1:0] idx, input logic [OFFSET_W-1:0] val);
        if (idx == IDX_BANK)
            bank_bytes = val;
        else if (idx == IDX_HZ)
            clock_hz = val[HZ_W-1:0];
    endfunction

    function automatic rec_beat_t mk(input kind_t k, input logic [SEC_W-1:0] s,
                                     input logic [NSF_W-1:0] n, input logic [LEN_W-1:0] l,
                                     input logic [63:0] d, input logic lst);
        rec_beat_t r;
        r.kind = k; r.sec = s; r.nsec = n; r.len = l; r.data = d; r.last = lst;
        return r;
    endfunction

    function automatic void next_cycle();
        logic [OFFSET_W:0] nxt;
        nxt = {1'b0, cur_offset} + CYCLE_BYTES;
        cur_offset = nxt[OFFSET_W] ? OFFSET_MAX : nxt[OFFSET_W-1:0];
        word_idx = 0;
    endfunction

    // Advance the deframer state by one memory word; return 1 when a beat comes out.
    function automatic bit deframe_word(input logic [63:0] w, output rec_beat_t r);
        logic [63:0] div, ns;
        logic [LEN_W-1:0] l;
        bit got;
        got = 0;
        r = mk(K_HEADER, '0, '0, '0, '0, 1'b0);
        if (phase == PH_HDR)
        begin
            if (word_idx == 0)
            begin
                if (cur_offset >= bank_bytes || w[55:0] != SIG_VALUE)
                begin
                    phase = PH_STOP;
                    r = mk(K_END, '0, '0, '0, '0, 1'b1);
                    return 1;
                end
            end
            else if (word_idx == 1)
            begin
                ts_clocks = w;
            end
            else if (word_idx == 2)
            begin
                l = w[15:0];
                div = (clock_hz == 0) ? 64'd1 : {32'd0, clock_hz};
                if (l > MAX_LEN)
                begin
                    phase = PH_STOP;
                    r = mk(K_ERROR, '0, '0, l, '0, 1'b1);
                    return 1;
                end
                if ({29'd0, cur_offset} + CYCLE_BYTES + l > {29'd0, bank_bytes})
                begin
                    phase = PH_STOP;
                    r = mk(K_END, '0, '0, '0, '0, 1'b1);
                    return 1;
                end
                ns = (ts_clocks * NS_PER_S) / div;
                rec_len = l;
                bytes_left = l;
                r = mk(K_HEADER, SEC_W'(ns / NS_PER_S), NSF_W'(ns % NS_PER_S), l, '0,
                       l == 0);
                got = 1;
            end
            if (word_idx >= 7)
            begin
                next_cycle();
                phase = (bytes_left != 0) ? PH_DAT : PH_HDR;
            end
            else
            begin
                word_idx++;
            end
            return got;
        end
        if (phase == PH_DAT)
        begin
            if (bytes_left != 0)
            begin
                r = mk(K_DATA, '0, '0, rec_len, w, bytes_left <= 8);
                bytes_left = (bytes_left <= 8) ? 0 : bytes_left - 8;
                got = 1;
            end
            if (word_idx >= 7)
            begin
                next_cycle();
                if (bytes_left == 0)
                    phase = PH_HDR;
            end
            else
            begin
                word_idx++;
            end
        end
        return got;
    endfunction

    // Drive one input beat with random idle, then predict at acceptance.
    task automatic send_beat(input logic [63:0] w, input bit typed, input rec_beat_t texp);
        rec_beat_t r;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            ram_word <= 64'($urandom());
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ram_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (deframe_word(w, r))
            pending_beats.push_back(typed ? texp : r);
    endtask

    task automatic send_plain(input logic [63:0] w);
        send_beat(w, 0, mk(K_HEADER, '0, '0, '0, '0, 1'b0));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0)
            @(posedge clk);
        // header word 2 may still be dividing with nothing owed
        repeat (300) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [OFFSET_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        write_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] rand_data();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return rand64();
        endcase
    endfunction

    task automatic send_record(input logic [LEN_W-1:0] len, input logic [63:0] ts);
        int unsigned ncyc;
        send_plain({8'($urandom()), SIG_VALUE});
        send_plain(ts);
        send_plain({48'(rand64()), len});
        repeat (5) send_plain(rand64());
        ncyc = (len + 63) / 64;
        repeat (ncyc * 8) send_plain(rand_data());
    endtask

    function automatic logic [LEN_W-1:0] pick_len();
        case ($urandom_range(19))
            0: return LEN_W'(0);
            1: return LEN_W'($urandom_range(1024, 200));
            2: return LEN_W'(8 * $urandom_range(16));
            default: return LEN_W'($urandom_range(120));
        endcase
    endfunction

    function automatic logic [63:0] pick_ts();
        case ($urandom_range(5))
            0: return '1;
            1: return '0;
            2: return {32'd0, $urandom()};
            default: return rand64();
        endcase
    endfunction

    task automatic random_records(input int words);
        repeat (words / 24) send_record(pick_len(), pick_ts());
    endtask

    initial
    begin
        rec_beat_t none;
        bank_bytes = '0; clock_hz = 1; cur_offset = '0; phase = PH_HDR;
        word_idx = 0; ts_clocks = '0; rec_len = '0; bytes_left = 0;
        none = mk(K_HEADER, '0, '0, '0, '0, 1'b0);

        // extremes table: zero-length record, then max timestamp with one data beat
        dir_rows.push_back('{64'hFF66_6C6F_5720_2E44, 0, none});
        dir_rows.push_back('{64'h0, 0, none});
        dir_rows.push_back('{64'hFFFF_FFFF_FFFF_0000, 1,
                             mk(K_HEADER, '0, '0, 16'd0, '0, 1'b1)});
        for (int i = 0; i < 5; i++)
            dir_rows.push_back('{(i % 2) ? 64'h0 : '1, 0, none});
        dir_rows.push_back('{{8'h00, SIG_VALUE}, 0, none});
        dir_rows.push_back('{'1, 0, none});
        dir_rows.push_back('{64'h0000_0000_0000_0008, 0, none});
        for (int i = 0; i < 5; i++)
            dir_rows.push_back('{'1, 0, none});
        dir_rows.push_back('{'1, 1, mk(K_DATA, '0, '0, 16'd8, '1, 1'b1)});
        for (int i = 0; i < 7; i++)
            dir_rows.push_back('{(i % 2) ? '1 : 64'h0, 0, none});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cfg_write(IDX_BAD, '1);
        cfg_write(IDX_BANK, OFFSET_MAX);
        cfg_write(IDX_HZ, 1);
        foreach (dir_rows[i])
            send_beat(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].exp);
        wait_drained();

        cfg_write(IDX_HZ, $urandom());
        random_records(150);
        idle_pct = 0;
        random_records(150);
        idle_pct = 22;
        wait_drained();

        cfg_write(IDX_HZ, 0);
        cfg_write(IDX_BANK, {1'b1, 34'($urandom())});
        random_records(150);
        wait_drained();

        cfg_write(IDX_HZ, 32'hFFFF_FFFF);
        cfg_write(IDX_BAD, '0);
        random_records(150);
        wait_drained();

        // close the capture with one of the stopping conditions
        case ($urandom_range(4))
            0:
            begin
                cfg_write(IDX_BANK, cur_offset);
                send_plain({8'($urandom()), SIG_VALUE});
            end
            1: send_plain({8'($urandom()), SIG_VALUE ^ (56'd1 << $urandom_range(55))});
            2:
            begin
                send_plain({8'($urandom()), SIG_VALUE});
                send_plain(rand64());
                send_plain({48'($urandom()), 16'($urandom_range(65535, MAX_LEN + 1))});
            end
            default:
            begin
                cfg_write(IDX_BANK, cur_offset + CYCLE_BYTES + 99);
                send_plain({8'($urandom()), SIG_VALUE});
                send_plain(rand64());
                send_plain({48'd0, 16'd100});
            end
        endcase
        // stopped: these must produce nothing
        repeat (12) send_plain({8'($urandom()), SIG_VALUE});
        wait_drained();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // random output back-pressure, quiet during the no-idle stretch
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < idle_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rec_beat_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_beats.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat kind=%0d len=%0d", kind, packet_length);
            end
            else
            begin
                e = pending_beats.pop_front();
                if (kind != e.kind || stamp_sec != e.sec || stamp_nsec != e.nsec ||
                    packet_length != e.len || data_word != e.data || last != e.last)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch exp k=%0d s=%0d ns=%0d len=%0d d=%h l=%0d",
                                 e.kind, e.sec, e.nsec, e.len, e.data, e.last);
                        $display("         got k=%0d s=%0d ns=%0d len=%0d d=%h l=%0d",
                                 kind, stamp_sec, stamp_nsec, packet_length,
                                 data_word, last);
                    end
                end
            end
        end
    end
endmodule
